### hdl/qmd_pkg.sv
// Shared types and constants for the signed Q32.32 multiply/divide unit.
// No dependencies; used by q32_32_mul_div_unit.
package qmd_pkg;

	localparam int FRAC_BITS_DEF = 32;
	localparam int QBITS         = 63;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	localparam logic FUNC_MUL = 1'b0;
	localparam logic FUNC_DIV = 1'b1;

	typedef struct packed {
		logic               func;
		logic signed [63:0] operand_a;
		logic signed [63:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [63:0] result;
		logic [1:0]         status;
	} rsp_t;

endpackage

### hdl/q32_32_mul_div_unit.sv
// Signed Q32.32 multiply/divide unit, a fully pipelined datapath.
// Depends on qmd_pkg for the beat types and status codes.
//
// Usage: a request beat (func, operand_a, operand_b) enters on req when
// req_valid and req_ready are both high; one response beat (result, status)
// leaves on rsp for every request, in request order.
// Multiply forms the exact 128-bit product and shifts it right
// arithmetically by FRAC_BITS; divide shifts the dividend magnitude left by
// FRAC_BITS and divides by the divisor magnitude, truncating toward zero.
// Status 1 flags a product outside the signed 64-bit range or a quotient
// magnitude above 2^63-1, status 2 a zero divisor; the result is then zero.
// Registers from request to response: one stage forms the
// magnitudes, one stage forms the partial products and the divide overflow
// check, 63 stages each retire one quotient bit with a 65-bit
// compare-and-subtract (the multiply finishes in the first two of them), and
// the output register picks the result. Throughput is one beat per cycle.
// The whole pipeline advances together; when the response sits unaccepted,
// every stage holds and req_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module q32_32_mul_div_unit #(
	parameter int FRAC_BITS = qmd_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  qmd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output qmd_pkg::rsp_t rsp
);

	localparam int NSTEP = qmd_pkg::QBITS;

	// Per-stage payload. Divide and multiply fields share one record; each
	// stage only works on the fields that belong to it.
	typedef struct packed {
		logic          func;
		logic          neg;
		logic          div0;
		logic          over;
		logic [63:0]   d;
		logic [63:0]   rem;
		logic [62:0]   nlo;
		logic [62:0]   q;
		logic [63:0]   pll;
		logic [63:0]   plh;
		logic [63:0]   phl;
		logic [63:0]   phh;
		logic [127:0]  prod;
		logic [63:0]   mres;
		logic          movf;
	} dp_t;

	// The pipeline moves as one when the output register is free or drained.
	logic en;
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	// Stage 1: signs and magnitudes.
	logic        vld_s1;
	logic        func_s1;
	logic        neg_s1;
	logic        div0_s1;
	logic [63:0] ma_s1;
	logic [63:0] mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= req.func;
			neg_s1  <= req.operand_a[63] ^ req.operand_b[63];
			div0_s1 <= (req.operand_b == 64'sd0);
			ma_s1   <= req.operand_a[63] ? (~req.operand_a + 64'd1) : req.operand_a;
			mb_s1   <= req.operand_b[63] ? (~req.operand_b + 64'd1) : req.operand_b;
		end
	end

	// Stage 2: partial products, and the divide overflow check. The quotient
	// exceeds 2^63-1 exactly when the dividend bits from position 63 upward
	// already reach the divisor; otherwise they are the running remainder.
	logic [127:0] num_s1;
	logic [63:0]  nhi_s1;
	assign num_s1 = {64'd0, ma_s1} << FRAC_BITS;
	assign nhi_s1 = num_s1[126:63];

	dp_t  st   [0:NSTEP];
	logic vld  [0:NSTEP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[0].func <= func_s1;
			st[0].neg  <= neg_s1;
			st[0].div0 <= div0_s1;
			st[0].over <= (nhi_s1 >= mb_s1);
			st[0].d    <= mb_s1;
			st[0].rem  <= nhi_s1;
			st[0].nlo  <= num_s1[62:0];
			st[0].q    <= '0;
			st[0].pll  <= {32'd0, ma_s1[31:0]} * {32'd0, mb_s1[31:0]};
			st[0].plh  <= {32'd0, ma_s1[31:0]} * {32'd0, mb_s1[63:32]};
			st[0].phl  <= {32'd0, ma_s1[63:32]} * {32'd0, mb_s1[31:0]};
			st[0].phh  <= {32'd0, ma_s1[63:32]} * {32'd0, mb_s1[63:32]};
			st[0].prod <= '0;
			st[0].mres <= '0;
			st[0].movf <= 1'b0;
		end
	end

	// Quotient stages: one restoring-division bit each. The multiply sums
	// its partial products in the first and signs, shifts and range-checks
	// in the second.
	for (genvar j = 1; j <= NSTEP; j++) begin : g_step
		logic [64:0]  trial;
		logic         ge;
		logic [63:0]  rem_nx;
		logic [127:0] psum;
		logic [127:0] pneg;
		logic [127:0] psh;
		logic         fits;
		dp_t          nx;

		assign trial  = {st[j-1].rem, st[j-1].nlo[62]};
		assign ge     = (trial >= {1'b0, st[j-1].d});
		assign rem_nx = ge ? 64'(trial - {1'b0, st[j-1].d}) : trial[63:0];

		assign psum = {64'd0, st[j-1].pll}
			+ ({64'd0, st[j-1].plh} << 32)
			+ ({64'd0, st[j-1].phl} << 32)
			+ {st[j-1].phh, 64'd0};
		assign pneg = st[j-1].neg ? (~st[j-1].prod + 128'd1) : st[j-1].prod;
		assign psh  = 128'($signed(pneg) >>> FRAC_BITS);
		assign fits = (psh[127:63] == '0) || (psh[127:63] == '1);

		always_comb begin
			nx     = st[j-1];
			nx.rem = rem_nx;
			nx.nlo = {st[j-1].nlo[61:0], 1'b0};
			nx.q   = {st[j-1].q[61:0], ge};
			if (j == 1) begin
				nx.prod = psum;
			end
			if (j == 2) begin
				nx.mres = psh[63:0];
				nx.movf = !fits;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[j] <= 1'b0;
			end else if (en) begin
				vld[j] <= vld[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st[j] <= nx;
			end
		end
	end

	// Output register: select and finish the result.
	qmd_pkg::rsp_t fin;
	dp_t           last;
	assign last = st[NSTEP];

	always_comb begin
		if (last.func == qmd_pkg::FUNC_DIV) begin
			if (last.div0) begin
				fin.result = '0;
				fin.status = qmd_pkg::ST_DIV0;
			end else if (last.over) begin
				fin.result = '0;
				fin.status = qmd_pkg::ST_OVF;
			end else begin
				fin.result = last.neg ? -$signed({1'b0, last.q}) : $signed({1'b0, last.q});
				fin.status = qmd_pkg::ST_OK;
			end
		end else begin
			fin.result = last.movf ? 64'sd0 : $signed(last.mres);
			fin.status = last.movf ? qmd_pkg::ST_OVF : qmd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= vld[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp <= fin;
		end
	end

	// An error status always comes with a zero result.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != qmd_pkg::ST_OK) |-> rsp.result == 64'sd0)
		else $error("error status with nonzero result");

	// Only the three defined status codes ever leave the block.
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == qmd_pkg::ST_OK) || (rsp.status == qmd_pkg::ST_OVF)
			|| (rsp.status == qmd_pkg::ST_DIV0))
		else $error("undefined status code");

	// The input side only stalls while a response is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without a held response");

endmodule

### test/tb_q32_32_mul_div_unit.sv
// Self-checking testbench for the signed Q32.32 multiply/divide unit.
// Depends on qmd_pkg and q32_32_mul_div_unit; drives directed and random beats
// with random idling on both sides and checks every response in order.
module tb_q32_32_mul_div_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB        = 32;
	localparam int LATENCY   = 66;
	localparam int N_RANDOM  = 1700;
	localparam int LONG_HOLD = 200;

	localparam logic       F_MUL  = qmd_pkg::FUNC_MUL;
	localparam logic       F_DIV  = qmd_pkg::FUNC_DIV;
	localparam logic [1:0] S_OK   = qmd_pkg::ST_OK;
	localparam logic [1:0] S_OVF  = qmd_pkg::ST_OVF;
	localparam logic [1:0] S_DIV0 = qmd_pkg::ST_DIV0;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	qmd_pkg::req_t  req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	qmd_pkg::rsp_t  rsp;

	q32_32_mul_div_unit #(.FRAC_BITS(FB)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Expected responses, oldest first.
	qmd_pkg::rsp_t exp_rsp_q[$];
	int   n_fail = 0;
	int   n_checked = 0;
	int   n_mul = 0, n_div = 0, n_ovf = 0, n_div0 = 0;
	// When set, the receiver holds rsp_ready low for one long stretch set by LONG_HOLD.
	bit   hold_req = 1'b0;

	function automatic logic [63:0] mag64(logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// Predicts one response from one request beat.
	function automatic qmd_pkg::rsp_t q_arith(qmd_pkg::req_t r);
		qmd_pkg::rsp_t  o;
		logic           neg;
		logic [127:0]   prod;
		logic [127:0]   shifted;
		logic [127:0]   num;
		logic [127:0]   quo;
		logic [63:0]    a, b;
		a   = r.operand_a;
		b   = r.operand_b;
		neg = a[63] ^ b[63];
		o   = '0;
		if (r.func == F_MUL) begin
			prod = {64'd0, mag64(a)} * {64'd0, mag64(b)};
			if (neg)
				prod = ~prod + 128'd1;
			shifted = $signed(prod) >>> FB;
			// Fits when the upper 65 bits are all equal.
			if (shifted[127:63] == '0 || shifted[127:63] == '1) begin
				o.result = shifted[63:0];
				o.status = S_OK;
			end else begin
				o.status = S_OVF;
			end
		end else if (b == 64'd0) begin
			o.status = S_DIV0;
		end else begin
			num = {64'd0, mag64(a)} << FB;
			quo = num / {64'd0, mag64(b)};
			// A magnitude of 2^63 overflows even for a negative quotient.
			if (quo > 128'h7FFF_FFFF_FFFF_FFFF) begin
				o.status = S_OVF;
			end else begin
				o.result = neg ? (~quo[63:0] + 64'd1) : quo[63:0];
				o.status = S_OK;
			end
		end
		return o;
	endfunction

	// Directed table. A check flag marks rows whose response is typed in.
	typedef struct {
		qmd_pkg::req_t r;
		bit            chk;
		qmd_pkg::rsp_t e;
	} vec_t;

	localparam logic [63:0] MAXP = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ONE  = 64'h0000_0001_0000_0000;
	localparam logic [63:0] MONE = 64'hFFFF_FFFF_0000_0000;

	vec_t dir_tab[] = '{
		'{'{F_MUL, 64'd0, 64'd0},     1, '{64'd0, S_OK}},
		'{'{F_MUL, ONE, ONE},         1, '{ONE, S_OK}},
		'{'{F_MUL, MAXP, ONE},        1, '{MAXP, S_OK}},
		'{'{F_MUL, MINN, ONE},        1, '{MINN, S_OK}},
		'{'{F_MUL, MINN, MONE},       1, '{64'd0, S_OVF}},
		'{'{F_MUL, MAXP, MAXP},       1, '{64'd0, S_OVF}},
		'{'{F_MUL, MINN, MINN},       1, '{64'd0, S_OVF}},
		'{'{F_MUL, MAXP, MINN},       1, '{64'd0, S_OVF}},
		'{'{F_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1}, 1, '{64'hFFFF_FFFF_FFFF_FFFF, S_OK}},
		'{'{F_MUL, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000}, 0, '{64'd0, S_OK}},
		'{'{F_DIV, ONE, 64'd0},       1, '{64'd0, S_DIV0}},
		'{'{F_DIV, MINN, 64'd0},      1, '{64'd0, S_DIV0}},
		'{'{F_DIV, 64'd0, 64'd0},     1, '{64'd0, S_DIV0}},
		'{'{F_DIV, ONE, ONE},         1, '{ONE, S_OK}},
		'{'{F_DIV, MAXP, ONE},        1, '{MAXP, S_OK}},
		'{'{F_DIV, MINN, ONE},        1, '{64'd0, S_OVF}},
		'{'{F_DIV, MINN, MONE},       1, '{64'd0, S_OVF}},
		'{'{F_DIV, MINN, MINN},       1, '{ONE, S_OK}},
		'{'{F_DIV, MAXP, 64'd1},      1, '{64'd0, S_OVF}},
		'{'{F_DIV, 64'd1, MAXP},      1, '{64'd0, S_OK}},
		'{'{F_DIV, 64'd0, MINN},      1, '{64'd0, S_OK}},
		'{'{F_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3}, 0, '{64'd0, S_OK}},
		'{'{F_DIV, MONE, MAXP},       0, '{64'd0, S_OK}},
		'{'{F_DIV, 64'h0000_0003_0000_0000, 64'h0000_0000_0000_0007}, 0, '{64'd0, S_OK}}
	};

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = MINN;
			1: v = MAXP;
			2: v = 64'd0;
			3: v = {{32{1'b0}}, $urandom()};
			4: v = {{32{1'b1}}, $urandom()};
			5: v = {$urandom_range(0, 7) == 0 ? 32'hFFFF_FFFF : 32'd0, $urandom()} ^
				{8'($urandom_range(0, 255)), 24'd0, 32'd0};
			6: v = $signed({$urandom(), $urandom()}) >>> $urandom_range(0, 63);
			default: v = {$urandom(), $urandom()};
		endcase
		return v;
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	// Offers one beat and waits until it is accepted.
	task automatic send_beat(qmd_pkg::req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		exp_rsp_q.push_back(q_arith(r));
		if (r.func == F_MUL) n_mul++; else n_div++;
		@(negedge clk);
	endtask

	// Sender: directed table, then random beats with idle gaps and pressure phases.
	initial begin
		int            gap;
		qmd_pkg::req_t r;
		bit            no_idle;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_tab[i]) begin
			send_beat(dir_tab[i].r);
			// Rows with a typed-in response replace the prediction for that beat.
			if (dir_tab[i].chk)
				exp_rsp_q[$] = dir_tab[i].e;
			gap = $urandom_range(0, 3);
			if (gap != 0) begin
				req_valid <= 1'b0;
				idle_cycles(gap);
			end
		end
		no_idle = 1'b0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 300 == 0)
				no_idle = ~no_idle;
			// The receiver stalls for a long stretch while beats keep coming.
			if (n == 400)
				hold_req = 1'b1;
			// Pause until the pipeline has drained completely.
			if (n == 900) begin
				req_valid <= 1'b0;
				while (exp_rsp_q.size() != 0)
					@(negedge clk);
				@(negedge clk);
			end
			r.func      = 1'($urandom_range(0, 1));
			r.operand_a = rand64();
			r.operand_b = $urandom_range(0, 15) == 0 ? 64'd0 : rand64();
			send_beat(r);
			gap = no_idle ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				idle_cycles(gap);
			end
		end
		req_valid <= 1'b0;
		while (exp_rsp_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d multiply and %0d divide beats; %0d overflow, %0d divide-by-zero.",
			n_mul, n_div, n_ovf, n_div0);
		$display("%0d responses compared, %0d mismatches.", n_checked, n_fail);
		if (n_fail == 0)
			$display("PASS q32_32_mul_div_unit");
		else
			$display("FAIL q32_32_mul_div_unit");
		$finish;
	end

	// Receiver: random stall per beat, plus one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Response checker, sampled at the rising edge.
	always @(posedge clk) begin
		qmd_pkg::rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (exp_rsp_q.size() == 0) begin
				$error("response beat with nothing expected: result=%h status=%0d",
					rsp.result, rsp.status);
				n_fail++;
			end else begin
				e = exp_rsp_q.pop_front();
				n_checked++;
				if (e.status == S_OVF) n_ovf++;
				if (e.status == S_DIV0) n_div0++;
				if (rsp.result !== e.result) begin
					$error("result: expected %h actual %h", e.result, rsp.result);
					n_fail++;
				end
				if (rsp.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, rsp.status);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("FAIL q32_32_mul_div_unit");
		$finish;
	end

endmodule
